@@ sv/sra_pkg.sv @@
// Shared types and constants of the sparse row accumulator.
package sra_pkg;

    localparam int COL_W        = 10;
    localparam int VAL_W        = 32;
    localparam int FRAC_W       = 16;
    localparam int PROD_W       = 2 * VAL_W;
    localparam int SUM_W        = 48;
    localparam int TOL_W        = 47;
    localparam int COLS_DEFAULT = 1024;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic FUNC_ACC = 1'b0;
    localparam logic FUNC_POP = 1'b1;

    typedef struct packed {
        logic                    func;
        logic [COL_W-1:0]        column;
        logic signed [VAL_W-1:0] a_value;
        logic signed [VAL_W-1:0] b_value;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0]        out_column;
        logic signed [SUM_W-1:0] out_sum;
        logic                    kept;
        logic                    last;
        logic                    empty_res;
    } t_out_item;

endpackage

@@ sv/sra_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module sra_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/sparse_row_accumulator.sv @@
// Top level of the sparse row accumulator for a row-by-row sparse matrix product.
//
// Each column owns one word of a single on-chip memory that holds its signed
// Q32.16 running sum (48 bits, saturating) and its link in a list of the
// columns touched since they were last popped. An accumulate transaction
// multiplies a_value by b_value, floors the product to Q32.16, adds it to the
// column's sum and pushes a newly touched column onto the front of the list;
// it produces no result. A column at or beyond COLS is ignored. A pop
// transaction takes the column at the front of the list (the most recently
// first touched), returns its column, sum, a kept flag (|sum| strictly above
// zero_tolerance) and a last flag (the list is now empty), and clears the
// column's word. A pop on an empty list returns a result with only empty_res
// set. Items are handled one at a time: an accumulate does a memory read,
// then an add and write back; an ignored accumulate is accepted and dropped;
// a pop does a memory read, then a clear and unlink, then a load of the
// output register, which waits while a previous result still waits there.
// The output register lets accumulates proceed while a result waits. After
// reset the block runs a clearing pass over the memory, one word a cycle, and
// accepts no transaction until it ends; configuration writes are taken at any
// time. The user must write zero_tolerance only while the block is idle; the
// block itself does not enforce this.
module sparse_row_accumulator
    import sra_pkg::*;
#(
    parameter int COLS = COLS_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out,
    input  logic             i_cfg_we,
    input  logic [TOL_W-1:0] i_cfg_data
);

    localparam int IDX_W  = $clog2(COLS);
    localparam int LINK_W = $clog2(COLS + 2);
    localparam int CMP_W  = ((LINK_W > COL_W) ? LINK_W : COL_W) + 1;
    localparam int WORD_W = LINK_W + SUM_W;

    // The link value COLS ends the list; COLS + 1 marks a column not on it.
    localparam logic [LINK_W-1:0] END_MARK  = LINK_W'(COLS);
    localparam logic [LINK_W-1:0] UNLINKED  = LINK_W'(COLS + 1);
    localparam logic [WORD_W-1:0] INIT_WORD = {UNLINKED, {SUM_W{1'b0}}};
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(COLS - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_ACC   = 5'b00100,
        S_POP   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state                     r_state, n_state;
    logic [IDX_W-1:0]           r_clr_addr;
    logic [LINK_W-1:0]          r_head;
    logic [TOL_W-1:0]           r_tol;
    logic [IDX_W-1:0]           r_idx;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_empty;
    logic signed [SUM_W-1:0]    r_pop_sum;
    logic [SUM_W-1:0]           r_pop_mag;
    logic                       r_pop_last;
    logic                       r_out_valid;
    t_out_item                  r_out;

    logic                       w_in_fire;
    logic                       w_col_ok;
    logic [IDX_W-1:0]           w_raddr;
    logic [WORD_W-1:0]          w_rdata;
    logic                       w_we;
    logic [IDX_W-1:0]           w_waddr;
    logic [WORD_W-1:0]          w_wdata;
    logic [LINK_W-1:0]          w_rd_link;
    logic signed [SUM_W-1:0]    w_rd_sum;
    logic signed [SUM_W-1:0]    w_delta;
    logic [SUM_W:0]             w_sum_ext;
    logic signed [SUM_W-1:0]    w_new_sum;
    logic [LINK_W-1:0]          w_new_link;
    logic [LINK_W-1:0]          w_pop_next;
    logic [SUM_W-1:0]           w_mag;
    logic                       w_emit;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_col_ok   = CMP_W'(i_in.column) < CMP_W'(COLS);
    assign w_emit     = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    // One word per column: link in the upper bits, running sum below.
    assign w_rd_link = w_rdata[WORD_W-1:SUM_W];
    assign w_rd_sum  = w_rdata[SUM_W-1:0];

    // The exact product floored to Q32.16 always fits in the sum width.
    assign w_delta   = r_prod[FRAC_W +: SUM_W];
    assign w_sum_ext = {w_rd_sum[SUM_W-1], w_rd_sum} + {w_delta[SUM_W-1], w_delta};

    always_comb begin
        if (w_sum_ext[SUM_W] != w_sum_ext[SUM_W-1]) begin
            w_new_sum = w_sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            w_new_sum = w_sum_ext[SUM_W-1:0];
        end
    end

    // A column touched for the first time goes to the front of the list.
    assign w_new_link = (w_rd_link == UNLINKED) ? r_head : w_rd_link;
    assign w_pop_next = (w_rd_link > END_MARK) ? END_MARK : w_rd_link;
    assign w_mag      = w_rd_sum[SUM_W-1] ? (SUM_W'(0) - w_rd_sum) : w_rd_sum;

    // A pop reads the head column, an accumulate reads its own column.
    assign w_raddr = (i_in.func == FUNC_POP) ? IDX_W'(r_head) : IDX_W'(i_in.column);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = INIT_WORD;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
            end
            S_ACC: begin
                w_we    = 1'b1;
                w_wdata = {w_new_link, w_new_sum};
            end
            S_POP: begin
                w_we    = !r_empty;
            end
            default: begin
            end
        endcase
    end

    sra_ram #(
        .WIDTH (WORD_W),
        .DEPTH (COLS)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_fire) begin
                    if (i_in.func == FUNC_POP) begin
                        n_state = S_POP;
                    end else if (w_col_ok) begin
                        n_state = S_ACC;
                    end
                end
            end
            S_ACC: begin
                n_state = S_IDLE;
            end
            S_POP: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_head      <= END_MARK;
            r_tol       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                r_tol <= i_cfg_data;
            end
            if ((r_state == S_ACC) && (w_rd_link == UNLINKED)) begin
                r_head <= LINK_W'(r_idx);
            end else if ((r_state == S_POP) && !r_empty) begin
                r_head <= w_pop_next;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_idx   <= w_raddr;
            r_prod  <= i_in.a_value * i_in.b_value;
            r_empty <= (r_head >= END_MARK);
        end
        if (r_state == S_POP) begin
            if (r_empty) begin
                r_pop_sum  <= '0;
                r_pop_mag  <= '0;
                r_pop_last <= 1'b0;
            end else begin
                r_pop_sum  <= w_rd_sum;
                r_pop_mag  <= w_mag;
                r_pop_last <= (w_pop_next == END_MARK);
            end
        end
        if (w_emit) begin
            r_out.out_column <= r_empty ? '0 : COL_W'(r_idx);
            r_out.out_sum    <= r_pop_sum;
            r_out.kept       <= !r_empty && (r_pop_mag > {1'b0, r_tol});
            r_out.last       <= r_pop_last;
            r_out.empty_res  <= r_empty;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_pop_goes_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (i_in.func == FUNC_POP)) |=> (r_state == S_POP))
        else $error("pop transaction did not start its memory read");

    a_head_never_unlinked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head <= END_MARK))
        else $error("list head holds a value beyond the end marker");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("transaction accepted during the clearing pass");

    a_empty_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.empty_res) |-> (!o_out.kept && !o_out.last))
        else $error("empty pop result carries kept or last");

    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) || (r_state == S_EMIT)) |-> !w_we)
        else $error("memory written outside a read-modify-write step");

endmodule
